>>> rtl/core/skmk_pkg.sv
`default_nettype none

package skmk_pkg;

   // Default structure sizes
   localparam int NUM_MODULES_DEF = 4;
   localparam int ANGLE_BITS_DEF  = 16;

   // Register reset values
   localparam logic [14:0] MAX_SPEED_RST  = 15'd3200;
   localparam logic [15:0] MAX_WHEEL_RST  = 16'd25600;
   localparam logic [23:0] SPEED_SCALE_RST = 24'd65536;
   localparam logic [15:0] DEADBAND_RST   = 16'd128;
   localparam logic [9:0]  FRONT_X_RST    = 10'd160;
   localparam logic [9:0]  BACK_X_RST     = 10'd160;
   localparam logic [9:0]  SIDE_Y_RST     = 10'd160;

   // Register indexes
   localparam logic [2:0] CSR_MAX_SPEED   = 3'd0;
   localparam logic [2:0] CSR_MAX_WHEEL   = 3'd1;
   localparam logic [2:0] CSR_SPEED_SCALE = 3'd2;
   localparam logic [2:0] CSR_DEADBAND    = 3'd3;
   localparam logic [2:0] CSR_FRONT_X     = 3'd4;
   localparam logic [2:0] CSR_BACK_X      = 3'd5;
   localparam logic [2:0] CSR_SIDE_Y      = 3'd6;

   // Two pi in Q24
   localparam logic [27:0] TWO_PI_Q24 = 28'd105414357;

   // Datapath operations, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_VX,
      OP_SQ_VY,
      OP_SQ_MS,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_CL_MUL_X,
      OP_CL_MUL_Y,
      OP_DIV_INIT_M,
      OP_DIV_INIT_T,
      OP_DIV_STEP,
      OP_CL_SET_X,
      OP_CL_SET_Y,
      OP_ROT_X,
      OP_ROT_Y,
      OP_ROT_SCALE,
      OP_SET_CX,
      OP_SET_CY,
      OP_SQ_CX,
      OP_SQ_CY,
      OP_SUM,
      OP_MAG_SCALE,
      OP_SET_SP,
      OP_CORD_INIT,
      OP_CORD_NORM,
      OP_CORD_STEP,
      OP_CORD_END,
      OP_RS_MUL,
      OP_RS_SET,
      OP_SEND
   } skmk_op_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_SQ_VX,
      S_SQ_VY,
      S_SQ_MS,
      S_CMP,
      S_CL_SQI,
      S_CL_SQ,
      S_CL_MX,
      S_CL_DXI,
      S_CL_DX,
      S_CL_SX,
      S_CL_MY,
      S_CL_DYI,
      S_CL_DY,
      S_CL_SY,
      S_ROT_X,
      S_RSC_X,
      S_SET_CX,
      S_ROT_Y,
      S_RSC_Y,
      S_SET_CY,
      S_SQ_CX,
      S_SQ_CY,
      S_SUM,
      S_SQI,
      S_SQ,
      S_MAG,
      S_SET_SP,
      S_CI,
      S_CN,
      S_CS,
      S_CE,
      S_TOP,
      S_RS_MUL,
      S_RS_DI,
      S_RS_D,
      S_RS_SET,
      S_SEND
   } skmk_state_type;

   typedef struct packed {
      skmk_op_type op;
   } skmk_cmd_type;

   typedef struct packed {
      logic cmp_gt;
      logic sqrt_last;
      logic div_last;
      logic vec_zero;
      logic norm_done;
      logic cordic_last;
      logic mod_last;
      logic top_gt;
   } skmk_status_type;

   // Arctangent of 2^-i in 2^32 units per turn
   function automatic logic [31:0] atan_turns(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd3;
         5'd29: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/swerve_module_kinematics_unit.sv
`default_nettype none
// Sequence: the clamp test, a clamp of the translation if too fast, then per module the
// rotation terms, magnitude and CORDIC heading (shifts and steps skipped for a zero
// vector), the speed limit test, a rescale of all speeds if over the limit, then one
// result per module as rsp_tready allows. Throughput: one request at a time, bounded by
// the shared 28x28 multiplier, the bit-serial square root and divider and the CORDIC loop.
// Synchronous active-high reset restores register defaults and clears held headings.

module swerve_module_kinematics_unit #(
   parameter int NUM_MODULES = skmk_pkg::NUM_MODULES_DEF,
   parameter int ANGLE_BITS  = skmk_pkg::ANGLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // vel_x, vel_y, rot_rate
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // wheel_speed, wheel_angle
   output logic [1:0]       rsp_tuser,   // module_index
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import skmk_pkg::*;

   skmk_cmd_type    cmd;
   skmk_status_type status;
   logic [15:0]     speed, angle;

   // Register writes are always accepted and land in the next cycle
   assign csr_ready = 1'b1;
   assign rsp_tdata = {angle, speed};

   skmk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   skmk_dpath #(
      .NUM_MODULES (NUM_MODULES),
      .ANGLE_BITS  (ANGLE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_wr    (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_tdata),
      .rsp_index (rsp_tuser),
      .rsp_speed (speed),
      .rsp_angle (angle),
      .rsp_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/core/skmk_ctrl.sv
`default_nettype none

module skmk_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire skmk_pkg::skmk_status_type status,
   output skmk_pkg::skmk_cmd_type         cmd
);
   import skmk_pkg::*;

   skmk_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence the datapath
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SQ_VX;
            end
         end
         S_SQ_VX: begin cmd.op = OP_SQ_VX; state_in = S_SQ_VY; end
         S_SQ_VY: begin cmd.op = OP_SQ_VY; state_in = S_SQ_MS; end
         S_SQ_MS: begin cmd.op = OP_SQ_MS; state_in = S_CMP; end
         S_CMP: begin
            state_in = status.cmp_gt ? S_CL_SQI : S_ROT_X;
         end
         S_CL_SQI: begin cmd.op = OP_SQRT_INIT; state_in = S_CL_SQ; end
         S_CL_SQ: begin
            cmd.op = OP_SQRT_STEP;
            if (status.sqrt_last) state_in = S_CL_MX;
         end
         S_CL_MX:  begin cmd.op = OP_CL_MUL_X; state_in = S_CL_DXI; end
         S_CL_DXI: begin cmd.op = OP_DIV_INIT_M; state_in = S_CL_DX; end
         S_CL_DX: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) state_in = S_CL_SX;
         end
         S_CL_SX:  begin cmd.op = OP_CL_SET_X; state_in = S_CL_MY; end
         S_CL_MY:  begin cmd.op = OP_CL_MUL_Y; state_in = S_CL_DYI; end
         S_CL_DYI: begin cmd.op = OP_DIV_INIT_M; state_in = S_CL_DY; end
         S_CL_DY: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) state_in = S_CL_SY;
         end
         S_CL_SY:  begin cmd.op = OP_CL_SET_Y; state_in = S_ROT_X; end
         S_ROT_X:  begin cmd.op = OP_ROT_X; state_in = S_RSC_X; end
         S_RSC_X:  begin cmd.op = OP_ROT_SCALE; state_in = S_SET_CX; end
         S_SET_CX: begin cmd.op = OP_SET_CX; state_in = S_ROT_Y; end
         S_ROT_Y:  begin cmd.op = OP_ROT_Y; state_in = S_RSC_Y; end
         S_RSC_Y:  begin cmd.op = OP_ROT_SCALE; state_in = S_SET_CY; end
         S_SET_CY: begin cmd.op = OP_SET_CY; state_in = S_SQ_CX; end
         S_SQ_CX:  begin cmd.op = OP_SQ_CX; state_in = S_SQ_CY; end
         S_SQ_CY:  begin cmd.op = OP_SQ_CY; state_in = S_SUM; end
         S_SUM:    begin cmd.op = OP_SUM; state_in = S_SQI; end
         S_SQI:    begin cmd.op = OP_SQRT_INIT; state_in = S_SQ; end
         S_SQ: begin
            cmd.op = OP_SQRT_STEP;
            if (status.sqrt_last) state_in = S_MAG;
         end
         S_MAG:    begin cmd.op = OP_MAG_SCALE; state_in = S_SET_SP; end
         S_SET_SP: begin cmd.op = OP_SET_SP; state_in = S_CI; end
         S_CI: begin
            cmd.op   = OP_CORD_INIT;
            state_in = status.vec_zero ? S_CE : S_CN;
         end
         S_CN: begin
            cmd.op = OP_CORD_NORM;
            if (status.norm_done) state_in = S_CS;
         end
         S_CS: begin
            cmd.op = OP_CORD_STEP;
            if (status.cordic_last) state_in = S_CE;
         end
         S_CE: begin
            cmd.op   = OP_CORD_END;
            state_in = status.mod_last ? S_TOP : S_ROT_X;
         end
         S_TOP: begin
            state_in = status.top_gt ? S_RS_MUL : S_SEND;
         end
         S_RS_MUL: begin cmd.op = OP_RS_MUL; state_in = S_RS_DI; end
         S_RS_DI:  begin cmd.op = OP_DIV_INIT_T; state_in = S_RS_D; end
         S_RS_D: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) state_in = S_RS_SET;
         end
         S_RS_SET: begin
            cmd.op   = OP_RS_SET;
            state_in = status.mod_last ? S_SEND : S_RS_MUL;
         end
         S_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.op = OP_SEND;
               if (status.mod_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/skmk_dpath.sv
`default_nettype none

module skmk_dpath #(
   parameter int NUM_MODULES = skmk_pkg::NUM_MODULES_DEF,
   parameter int ANGLE_BITS  = skmk_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire skmk_pkg::skmk_cmd_type cmd,
   output skmk_pkg::skmk_status_type   status,
   input  wire logic                   csr_wr,
   input  wire logic [2:0]             csr_index,
   input  wire logic [23:0]            csr_wdata,
   input  wire logic [47:0]            req_data,
   output logic [1:0]                  rsp_index,
   output logic [15:0]                 rsp_speed,
   output logic [15:0]                 rsp_angle,
   output logic                        rsp_last
);
   import skmk_pkg::*;

   localparam int MOD_W = $clog2(NUM_MODULES);
   localparam logic [31:0] QMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(NUM_MODULES - 1);
   localparam logic signed [41:0] NORM_LIM = 42'sh10_0000_0000;
   localparam logic [51:0] SQRT_BIT0 = 52'd1 << 50;

   // Configuration
   logic [14:0] max_speed_ff, max_speed_in;
   logic [15:0] max_wheel_ff, max_wheel_in;
   logic [23:0] scale_ff, scale_in;
   logic [15:0] deadband_ff, deadband_in;
   logic [9:0]  front_ff, front_in, back_ff, back_in, side_ff, side_in;

   // Control state
   logic [MOD_W-1:0] mod_ff, mod_in;

   // Working registers
   logic signed [15:0] vx_ff, vx_in, vy_ff, vy_in, w_ff, w_in;
   logic signed [55:0] prod_ff, prod_in;
   logic [51:0]        acc_ff, acc_in;
   logic [51:0]        rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [37:0]        num_ff, num_in;
   logic [21:0]        den_ff, den_in;
   logic [22:0]        rem_ff, rem_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic signed [26:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [41:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        z_ff, z_in;
   logic [4:0]         it_ff, it_in;
   logic [21:0]        top_ff, top_in;
   logic [21:0]        sp_ff   [NUM_MODULES];
   logic [21:0]        sp_in   [NUM_MODULES];
   logic [15:0]        ang_ff  [NUM_MODULES];
   logic [15:0]        ang_in  [NUM_MODULES];
   logic [15:0]        held_ff [NUM_MODULES];
   logic [15:0]        held_in [NUM_MODULES];

   // Combinational helpers
   logic signed [27:0] mul_a, mul_b;
   logic               mul_en;
   logic [1:0]         corner;
   logic signed [10:0] neg_py, pos_px;
   logic signed [16:0] v_abs;
   logic [15:0]        q16;
   logic signed [55:0] p_abs;
   logic [55:0]        p_rnd;
   logic signed [27:0] rot;
   logic signed [26:0] vel_sh;
   logic [51:0]        trial;
   logic [22:0]        rem_sh;
   logic signed [41:0] y_abs, dx, dy;
   logic               norm_go;
   logic [21:0]        cur_sp;
   logic               pass;
   logic               mod_last;
   logic [MOD_W-1:0]   mod_next;

   assign corner   = mod_ff[1:0];
   assign mod_last = (mod_ff == MOD_LAST);
   assign mod_next = mod_last ? '0 : mod_ff + MOD_W'(1);
   assign neg_py   = corner[0] ? -$signed({1'b0, side_ff}) : $signed({1'b0, side_ff});
   assign pos_px   = corner[1] ? -$signed({1'b0, back_ff}) : $signed({1'b0, front_ff});
   assign q16      = num_ff[15:0];
   assign trial    = root_ff + bit_ff;
   assign rem_sh   = {rem_ff[21:0], num_ff[37]};
   assign y_abs    = y_ff[41] ? -y_ff : y_ff;
   assign norm_go  = (x_ff < NORM_LIM) && (y_abs < NORM_LIM);
   assign dx       = y_ff >>> it_ff;
   assign dy       = x_ff >>> it_ff;

   // Round the rotational term half away from zero
   assign p_abs = prod_ff[55] ? -prod_ff : prod_ff;
   assign p_rnd = p_abs + 56'(64'd1 << 27);
   assign rot   = prod_ff[55] ? -$signed({1'b0, p_rnd[54:28]})
                              : $signed({1'b0, p_rnd[54:28]});

   // Status towards the controller
   assign status.cmp_gt      = acc_ff > prod_ff[51:0];
   assign status.sqrt_last   = bit_ff[0];
   assign status.div_last    = (dcnt_ff == 6'd37);
   assign status.vec_zero    = (cx_ff == 27'sd0) && (cy_ff == 27'sd0);
   assign status.norm_done   = !norm_go;
   assign status.cordic_last = (it_ff == 5'd29);
   assign status.mod_last    = mod_last;
   assign status.top_gt      = top_ff > {6'd0, max_wheel_ff};

   // Result of the current module
   assign cur_sp    = sp_ff[mod_ff];
   assign pass      = cur_sp > {6'd0, deadband_ff};
   assign rsp_index = mod_ff[1:0];
   assign rsp_speed = !pass ? 16'd0 : (cur_sp > 22'h00FFFF) ? 16'hFFFF : cur_sp[15:0];
   assign rsp_angle = pass ? ang_ff[mod_ff] : held_ff[mod_ff];
   assign rsp_last  = mod_last;

   always_comb begin
      max_speed_in = max_speed_ff;
      max_wheel_in = max_wheel_ff;
      scale_in     = scale_ff;
      deadband_in  = deadband_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      side_in      = side_ff;
      mod_in  = mod_ff;
      vx_in   = vx_ff;
      vy_in   = vy_ff;
      w_in    = w_ff;
      acc_in  = acc_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      top_in  = top_ff;
      sp_in   = sp_ff;
      ang_in  = ang_ff;
      held_in = held_ff;
      mul_en  = 1'b0;
      mul_a   = '0;
      mul_b   = '0;
      v_abs   = '0;
      vel_sh  = '0;

      // Register writes
      if (csr_wr) begin
         case (csr_index)
            CSR_MAX_SPEED:   max_speed_in = csr_wdata[14:0];
            CSR_MAX_WHEEL:   max_wheel_in = csr_wdata[15:0];
            CSR_SPEED_SCALE: scale_in     = csr_wdata;
            CSR_DEADBAND:    deadband_in  = csr_wdata[15:0];
            CSR_FRONT_X:     front_in     = csr_wdata[9:0];
            CSR_BACK_X:      back_in      = csr_wdata[9:0];
            CSR_SIDE_Y:      side_in      = csr_wdata[9:0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            vx_in  = req_data[15:0];
            vy_in  = req_data[31:16];
            w_in   = req_data[47:32];
            mod_in = '0;
            top_in = '0;
         end
         OP_SQ_VX: begin
            mul_en = 1'b1;
            mul_a  = 28'(vx_ff);
            mul_b  = 28'(vx_ff);
         end
         OP_SQ_VY: begin
            acc_in = prod_ff[51:0];
            mul_en = 1'b1;
            mul_a  = 28'(vy_ff);
            mul_b  = 28'(vy_ff);
         end
         OP_SQ_MS: begin
            acc_in = acc_ff + prod_ff[51:0];
            mul_en = 1'b1;
            mul_a  = $signed({13'd0, max_speed_ff});
            mul_b  = $signed({13'd0, max_speed_ff});
         end
         OP_SQRT_INIT: begin
            rad_in  = acc_ff;
            root_in = '0;
            bit_in  = SQRT_BIT0;
         end
         OP_SQRT_STEP: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         OP_CL_MUL_X, OP_CL_MUL_Y: begin
            v_abs  = (cmd.op == OP_CL_MUL_X) ? 17'(vx_ff) : 17'(vy_ff);
            v_abs  = v_abs[16] ? -v_abs : v_abs;
            mul_en = 1'b1;
            mul_a  = $signed({11'd0, v_abs});
            mul_b  = $signed({13'd0, max_speed_ff});
         end
         OP_DIV_INIT_M, OP_DIV_INIT_T: begin
            num_in  = prod_ff[37:0];
            den_in  = (cmd.op == OP_DIV_INIT_M) ? {6'd0, root_ff[15:0]} : top_ff;
            rem_in  = '0;
            dcnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[36:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[36:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
         end
         OP_CL_SET_X: vx_in = vx_ff[15] ? $signed(16'd0 - q16) : $signed(q16);
         OP_CL_SET_Y: vy_in = vy_ff[15] ? $signed(16'd0 - q16) : $signed(q16);
         OP_ROT_X: begin
            mul_en = 1'b1;
            mul_a  = 28'(neg_py);
            mul_b  = 28'(w_ff);
         end
         OP_ROT_Y: begin
            mul_en = 1'b1;
            mul_a  = 28'(pos_px);
            mul_b  = 28'(w_ff);
         end
         OP_ROT_SCALE: begin
            mul_en = 1'b1;
            mul_a  = prod_ff[27:0];
            mul_b  = $signed(TWO_PI_Q24);
         end
         OP_SET_CX: begin
            vel_sh = {{3{vx_ff[15]}}, vx_ff, 8'd0};
            cx_in  = vel_sh + rot[26:0];
         end
         OP_SET_CY: begin
            vel_sh = {{3{vy_ff[15]}}, vy_ff, 8'd0};
            cy_in  = vel_sh + rot[26:0];
         end
         OP_SQ_CX: begin
            mul_en = 1'b1;
            mul_a  = 28'(cx_ff);
            mul_b  = 28'(cx_ff);
         end
         OP_SQ_CY: begin
            acc_in = prod_ff[51:0];
            mul_en = 1'b1;
            mul_a  = 28'(cy_ff);
            mul_b  = 28'(cy_ff);
         end
         OP_SUM: acc_in = acc_ff + prod_ff[51:0];
         OP_MAG_SCALE: begin
            mul_en = 1'b1;
            mul_a  = $signed({2'd0, root_ff[25:0]});
            mul_b  = $signed({4'd0, scale_ff});
         end
         OP_SET_SP: begin
            sp_in[mod_ff] = prod_ff[49:28];
            if (prod_ff[49:28] > top_ff) top_in = prod_ff[49:28];
         end
         OP_CORD_INIT: begin
            if (cx_ff[26]) begin
               x_in = -42'(cx_ff);
               y_in = -42'(cy_ff);
               z_in = 32'h8000_0000;
            end else begin
               x_in = 42'(cx_ff);
               y_in = 42'(cy_ff);
               z_in = '0;
            end
            it_in = '0;
         end
         OP_CORD_NORM: begin
            if (norm_go) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end
         end
         OP_CORD_STEP: begin
            if (y_ff[41]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_turns(it_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_turns(it_ff);
            end
            it_in = it_ff + 5'd1;
         end
         OP_CORD_END: begin
            ang_in[mod_ff] = z_ff[31:16] & QMASK[31:16];
            mod_in         = mod_next;
         end
         OP_RS_MUL: begin
            mul_en = 1'b1;
            mul_a  = $signed({6'd0, cur_sp});
            mul_b  = $signed({12'd0, max_wheel_ff});
         end
         OP_RS_SET: begin
            sp_in[mod_ff] = num_ff[21:0];
            mod_in        = mod_next;
         end
         OP_SEND: begin
            if (pass) held_in[mod_ff] = ang_ff[mod_ff];
            mod_in = mod_next;
         end
         default: ;
      endcase

      prod_in = mul_en ? mul_a * mul_b : prod_ff;
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= MAX_SPEED_RST;
         max_wheel_ff <= MAX_WHEEL_RST;
         scale_ff     <= SPEED_SCALE_RST;
         deadband_ff  <= DEADBAND_RST;
         front_ff     <= FRONT_X_RST;
         back_ff      <= BACK_X_RST;
         side_ff      <= SIDE_Y_RST;
         mod_ff       <= '0;
         for (int i = 0; i < NUM_MODULES; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         max_speed_ff <= max_speed_in;
         max_wheel_ff <= max_wheel_in;
         scale_ff     <= scale_in;
         deadband_ff  <= deadband_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         side_ff      <= side_in;
         mod_ff       <= mod_in;
         held_ff      <= held_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      it_ff   <= it_in;
      top_ff  <= top_in;
      sp_ff   <= sp_in;
      ang_ff  <= ang_in;
   end

endmodule

`default_nettype wire
